/* hdl/npcm_pkg.sv */
// ============================================================================
// npcm_pkg - shared definitions for the nearest palette colour matcher
// Holds the palette size default, operation codes, controller state type,
// command and status bundles, and the palette reset colour function.
// ============================================================================
`default_nettype none

package npcm_pkg;

   // Default number of palette entries.
   localparam int PALETTE_ENTRIES = 17;

   // Fixed field widths of the transaction payloads.
   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 5;
   localparam int CHAN_W   = 8;
   localparam int COLOUR_W = 3 * CHAN_W;
   localparam int WORD_W   = 11;
   localparam int DIST_W   = 18;

   // Operation codes carried in the func field.
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MATCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // EGA channel levels and special palette entries.
   localparam logic [CHAN_W-1:0] EGA_FULL    = 8'hA8;
   localparam logic [CHAN_W-1:0] EGA_HALF    = 8'h54;
   localparam logic [7:0]        BROWN_ENTRY = 8'd6;
   localparam logic [7:0]        KEY_ENTRY   = 8'd16;
   localparam logic [CHAN_W-1:0] KEY_RED     = 8'd100;
   localparam logic [CHAN_W-1:0] KEY_GREEN   = 8'd1;
   localparam logic [CHAN_W-1:0] KEY_BLUE    = 8'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic accept;     // capture the request fields, clear the search
      logic wr_en;      // write the captured colour to the palette
      logic scan_step;  // read the next palette entry into the distance pipe
      logic fetch;      // read the result entry
      logic load_out;   // load the response register
   } cmd_type;

   typedef struct packed {
      logic scan_last;  // scan counter points at the last entry
      logic pipe_busy;  // distance pipeline still holds entries
      logic out_free;   // response register can take a new result
   } status_type;

   // Colour of a palette entry after reset, packed as {red, green, blue}.
   function automatic logic [COLOUR_W-1:0] reset_colour(input logic [7:0] entry);
      logic [CHAN_W-1:0] hi;
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      hi = entry[3] ? EGA_HALF : '0;
      r  = (entry[2] ? EGA_FULL : '0) + hi;
      g  = (entry[1] ? EGA_FULL : '0) + hi;
      b  = (entry[0] ? EGA_FULL : '0) + hi;
      if (entry == BROWN_ENTRY) begin
         g = EGA_HALF;
      end else if (entry == KEY_ENTRY) begin
         r = KEY_RED;
         g = KEY_GREEN;
         b = KEY_BLUE;
      end else if (entry > KEY_ENTRY) begin
         r = '0;
         g = '0;
         b = '0;
      end
      return {r, g, b};
   endfunction

endpackage

`default_nettype wire

/* hdl/npcm_if.sv */
// ============================================================================
// npcm_if - request and response channel interfaces
// Valid/ready channels carrying the operation request and its result.
// ============================================================================
`default_nettype none

interface npcm_req_if;
   logic                          valid;
   logic                          ready;
   logic [npcm_pkg::FUNC_W-1:0]   func;
   logic [npcm_pkg::INDEX_W-1:0]  index;
   logic [npcm_pkg::CHAN_W-1:0]   red;
   logic [npcm_pkg::CHAN_W-1:0]   green;
   logic [npcm_pkg::CHAN_W-1:0]   blue;

   modport source (output valid, func, index, red, green, blue, input ready);
   modport sink   (input valid, func, index, red, green, blue, output ready);
endinterface

interface npcm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [npcm_pkg::INDEX_W-1:0]  match_index;
   logic [npcm_pkg::CHAN_W-1:0]   out_red;
   logic [npcm_pkg::CHAN_W-1:0]   out_green;
   logic [npcm_pkg::CHAN_W-1:0]   out_blue;
   logic [npcm_pkg::WORD_W-1:0]   st_colour_word;

   modport source (output valid, match_index, out_red, out_green, out_blue,
                   st_colour_word, input ready);
   modport sink   (input valid, match_index, out_red, out_green, out_blue,
                   st_colour_word, output ready);
endinterface

`default_nettype wire

/* hdl/nearest_palette_colour_matcher_unit.sv */
// ============================================================================
// nearest_palette_colour_matcher_unit - palette write, read and nearest match
// Keeps an RGB palette reset to the sixteen EGA colours plus a key colour,
// and returns the entry nearest a given colour by squared RGB distance.
// ============================================================================
//
//   Channel   Direction  Handshake     Payload
//   req_bus   in         valid/ready   func, index, red, green, blue
//   rsp_bus   out        valid/ready   match_index, out_red, out_green,
//                                      out_blue, st_colour_word
//
// A read transaction passes through the fetch and deliver states, a write
// through the write, fetch and deliver states, and a match through the scan,
// drain, fetch and deliver states: the search reads one palette entry per cycle
// through the single RAM read port, followed by a drain of the distance pipeline.
// Reset clears the valid bits of the palette, so entries that were never
// written read as their reset colour; reset needs no clearing pass.
// The response register holds a finished result while the response side
// stalls, and the next request is taken in the meantime; only a second result
// waits until the first has been taken.
//
`default_nettype none

module nearest_palette_colour_matcher_unit #(
   parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES
) (
   input  wire logic   clock,
   input  wire logic   reset,
   npcm_req_if.sink    req_bus,
   npcm_rsp_if.source  rsp_bus
);

   npcm_pkg::cmd_type    cmd;
   npcm_pkg::status_type status;
   logic                 req_ready;

   // The controller sequences each transaction; the datapath holds all storage.
   npcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_func  (req_bus.func),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_bus.ready = req_ready;

   npcm_datapath #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_func  (req_bus.func),
      .req_index (req_bus.index),
      .req_red   (req_bus.red),
      .req_green (req_bus.green),
      .req_blue  (req_bus.blue),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

/* hdl/npcm_ram.sv */
// ============================================================================
// npcm_ram - generic single write port RAM with registered read
// One write and one read per cycle; read data holds when no read is issued.
// ============================================================================
`default_nettype none

module npcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 17
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/npcm_ctrl.sv */
// ============================================================================
// npcm_ctrl - operation sequencer
// Steps each transaction through write, scan, drain, fetch and delivery.
// ============================================================================
`default_nettype none

module npcm_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [npcm_pkg::FUNC_W-1:0] req_func,
   output      logic                        req_ready,
   output      npcm_pkg::cmd_type           cmd,
   input  wire npcm_pkg::status_type        status
);

   npcm_pkg::state_type state_ff;
   npcm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         npcm_pkg::ST_IDLE: begin
            if (req_valid) begin
               priority if (req_func == npcm_pkg::FUNC_WRITE) begin
                  state_in = npcm_pkg::ST_WRITE;
               end else if (req_func == npcm_pkg::FUNC_MATCH) begin
                  state_in = npcm_pkg::ST_SCAN;
               end else begin
                  state_in = npcm_pkg::ST_FETCH;
               end
            end
         end
         npcm_pkg::ST_WRITE:   state_in = npcm_pkg::ST_FETCH;
         npcm_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = npcm_pkg::ST_DRAIN;
            end
         end
         npcm_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = npcm_pkg::ST_FETCH;
            end
         end
         npcm_pkg::ST_FETCH:   state_in = npcm_pkg::ST_DELIVER;
         npcm_pkg::ST_DELIVER: begin
            if (status.out_free) begin
               state_in = npcm_pkg::ST_IDLE;
            end
         end
         default:              state_in = npcm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         npcm_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         npcm_pkg::ST_WRITE:   cmd.wr_en     = 1'b1;
         npcm_pkg::ST_SCAN:    cmd.scan_step = 1'b1;
         npcm_pkg::ST_DRAIN:   cmd           = '0;
         npcm_pkg::ST_FETCH:   cmd.fetch     = 1'b1;
         npcm_pkg::ST_DELIVER: cmd.load_out  = status.out_free;
         default:              cmd           = '0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/npcm_datapath.sv */
// ============================================================================
// npcm_datapath - palette storage, distance pipeline and response register
// Holds the captured request, the palette RAM with its reset-valid bits,
// a two-stage squared distance pipeline and the best-entry tracker.
// ============================================================================
`default_nettype none

module npcm_datapath #(
   parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [npcm_pkg::FUNC_W-1:0]  req_func,
   input  wire logic [npcm_pkg::INDEX_W-1:0] req_index,
   input  wire logic [npcm_pkg::CHAN_W-1:0]  req_red,
   input  wire logic [npcm_pkg::CHAN_W-1:0]  req_green,
   input  wire logic [npcm_pkg::CHAN_W-1:0]  req_blue,
   input  wire npcm_pkg::cmd_type            cmd,
   output      npcm_pkg::status_type         status,
   npcm_rsp_if.source                        rsp
);

   localparam int AW = $clog2(PALETTE_ENTRIES);
   localparam int CW = npcm_pkg::CHAN_W;

   // Captured request.
   logic [npcm_pkg::FUNC_W-1:0]  func_ff;
   logic [npcm_pkg::INDEX_W-1:0] index_ff;
   logic [CW-1:0]                red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_func;
         index_ff <= req_index;
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
      end
   end

   logic          in_range;
   logic [AW-1:0] entry_addr;

   assign in_range   = int'(index_ff) < PALETTE_ENTRIES;
   assign entry_addr = in_range ? AW'(index_ff) : '0;

   // Scan counter and best-entry tracker.
   logic [AW-1:0]                scan_cnt_ff;
   logic [AW-1:0]                best_idx_ff;
   logic [npcm_pkg::DIST_W-1:0]  best_d_ff;

   // Palette RAM and read side.
   logic                         ram_we;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [npcm_pkg::COLOUR_W-1:0] ram_rdata;
   logic [AW-1:0]                rd_addr_ff;
   logic                         rd_valid_ff;
   logic [PALETTE_ENTRIES-1:0]   valid_ff;
   logic [npcm_pkg::COLOUR_W-1:0] rd_colour;

   assign ram_we    = cmd.wr_en && in_range;
   assign ram_re    = cmd.scan_step || cmd.fetch;
   assign ram_raddr = cmd.scan_step ? scan_cnt_ff
                    : ((func_ff == npcm_pkg::FUNC_MATCH) ? best_idx_ff : entry_addr);

   npcm_ram #(
      .WIDTH (npcm_pkg::COLOUR_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (entry_addr),
      .wr_data ({red_ff, green_ff, blue_ff}),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[entry_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_re) begin
         rd_addr_ff  <= ram_raddr;
         rd_valid_ff <= valid_ff[ram_raddr];
      end
   end

   // Entries never written read as their reset colour.
   assign rd_colour = rd_valid_ff ? ram_rdata : npcm_pkg::reset_colour(8'(rd_addr_ff));

   // Distance pipeline: stage one squares, stage two sums and compares.
   logic                 s1_ff, s2_ff;
   logic [CW-1:0]        dr, dg, db;
   logic [2*CW-1:0]      sq_r_ff, sq_g_ff, sq_b_ff;
   logic [AW-1:0]        tag_ff;
   logic [npcm_pkg::DIST_W-1:0] dist_sum;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   assign dr = abs_diff(red_ff,   rd_colour[3*CW-1:2*CW]);
   assign dg = abs_diff(green_ff, rd_colour[2*CW-1:CW]);
   assign db = abs_diff(blue_ff,  rd_colour[CW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.scan_step;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ff) begin
         sq_r_ff <= (2*CW)'(dr) * (2*CW)'(dr);
         sq_g_ff <= (2*CW)'(dg) * (2*CW)'(dg);
         sq_b_ff <= (2*CW)'(db) * (2*CW)'(db);
         tag_ff  <= rd_addr_ff;
      end
   end

   assign dist_sum = npcm_pkg::DIST_W'(sq_r_ff) + npcm_pkg::DIST_W'(sq_g_ff)
                   + npcm_pkg::DIST_W'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         scan_cnt_ff <= '0;
         best_idx_ff <= '0;
         best_d_ff   <= '1;
      end else begin
         if (cmd.scan_step) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
         // Strict compare keeps the lowest index among equal distances.
         if (s2_ff && (dist_sum < best_d_ff)) begin
            best_d_ff   <= dist_sum;
            best_idx_ff <= tag_ff;
         end
      end
   end

   // Response register.
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [npcm_pkg::INDEX_W-1:0]  out_index_ff;
   logic [npcm_pkg::COLOUR_W-1:0] out_colour_ff;

   assign out_valid_in = cmd.load_out ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_index_ff  <= npcm_pkg::INDEX_W'(rd_addr_ff);
         out_colour_ff <= rd_colour;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.match_index    = out_index_ff;
   assign rsp.out_red        = out_colour_ff[3*CW-1:2*CW];
   assign rsp.out_green      = out_colour_ff[2*CW-1:CW];
   assign rsp.out_blue       = out_colour_ff[CW-1:0];
   assign rsp.st_colour_word = {out_colour_ff[3*CW-1:3*CW-3], 1'b0,
                                out_colour_ff[2*CW-1:2*CW-3], 1'b0,
                                out_colour_ff[CW-1:CW-3]};

   assign status.scan_last = (scan_cnt_ff == AW'(PALETTE_ENTRIES - 1));
   assign status.pipe_busy = s1_ff || s2_ff;
   assign status.out_free  = !out_valid_ff || rsp.ready;

   // The best distance only ever shrinks while a scan drains.
   a_best_monotonic: assert property (@(posedge clock) disable iff (reset)
      (s2_ff && !cmd.accept) |=> (best_d_ff <= $past(best_d_ff)))
      else $error("best distance grew during a scan");

   // Writes and result fetches never overlap entries still in the distance pipe.
   a_pipe_quiet: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en || cmd.fetch) |-> (!s1_ff && !s2_ff))
      else $error("palette access while the distance pipe is busy");

   // A new result never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp.ready))
      else $error("response register overwritten");

   // Every reported entry exists in the palette.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (int'(rd_addr_ff) < PALETTE_ENTRIES))
      else $error("reported entry outside the palette");

endmodule

`default_nettype wire
